@@ sv/assert_macros.svh @@
// Assertion macros shared by the deque modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define BDQ_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BDQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/bdq_pkg.sv @@
// Types and codes shared by the bounded deque controller, datapath and top level.
package bdq_pkg;

   // Command codes carried in the request word.
   localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
   localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
   localparam logic [3:0] CMD_POP_FRONT  = 4'd2;
   localparam logic [3:0] CMD_POP_BACK   = 4'd3;
   localparam logic [3:0] CMD_REMOVE     = 4'd4;
   localparam logic [3:0] CMD_CLEAR      = 4'd5;
   localparam logic [3:0] CMD_READ_ALL   = 4'd6;
   localparam logic [3:0] CMD_READ_FIRST = 4'd7;
   localparam logic [3:0] CMD_READ_TAIL  = 4'd8;

   // Status codes carried in the response word.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Width of the entries_now field.
   localparam int ENW = 5;

   // Request word.
   typedef struct packed {
      logic [3:0]         cmd;
      logic signed [31:0] value;
      logic [4:0]         count_k;
   } req_word_type;

   // Response word.
   typedef struct packed {
      logic signed [31:0] item;
      logic               has_item;
      logic               item_last;
      logic [1:0]         status;
      logic [ENW-1:0]     entries_now;
   } rsp_word_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_SCAN,
      S_FINISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       emit;
      logic [1:0] emit_status;
      logic       push_write;
      logic       pop_issue;
      logic       clear_list;
      logic       read_start;
      logic       read_issue;
      logic       scan_start;
      logic       scan_issue;
      logic       scan_commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [3:0] cmd;
      logic       list_empty;
      logic       list_full;
      logic       read_none;
      logic       remain_zero;
      logic       pend;
      logic       scan_pend;
      logic       out_free;
   } dp_stat_type;

endpackage

@@ sv/bdq_ctrl.sv @@
// Controller state machine of the bounded deque.
`include "assert_macros.svh"

module bdq_ctrl import bdq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  dp_stat_type    stat,
   output ctrl_cmd_type   ctrl
);

   ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands to the datapath.
   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.cmd)
               CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                  if (stat.out_free) begin
                     ctrl.emit = 1'b1;
                     if (stat.list_full) begin
                        ctrl.emit_status = STATUS_FULL;
                     end else begin
                        ctrl.emit_status = STATUS_OK;
                        ctrl.push_write  = 1'b1;
                     end
                     state_in = S_IDLE;
                  end
               end
               CMD_POP_FRONT, CMD_POP_BACK: begin
                  if (stat.list_empty) begin
                     if (stat.out_free) begin
                        ctrl.emit        = 1'b1;
                        ctrl.emit_status = STATUS_EMPTY;
                        state_in         = S_IDLE;
                     end
                  end else begin
                     ctrl.pop_issue = 1'b1;
                     state_in       = S_READ;
                  end
               end
               CMD_REMOVE: begin
                  ctrl.scan_start = 1'b1;
                  state_in        = S_SCAN;
               end
               CMD_CLEAR: begin
                  if (stat.out_free) begin
                     ctrl.emit        = 1'b1;
                     ctrl.emit_status = STATUS_OK;
                     ctrl.clear_list  = 1'b1;
                     state_in         = S_IDLE;
                  end
               end
               CMD_READ_ALL, CMD_READ_FIRST, CMD_READ_TAIL: begin
                  if (stat.list_empty || stat.read_none) begin
                     if (stat.out_free) begin
                        ctrl.emit        = 1'b1;
                        ctrl.emit_status = stat.list_empty ? STATUS_EMPTY : STATUS_OK;
                        state_in         = S_IDLE;
                     end
                  end else begin
                     ctrl.read_start = 1'b1;
                     state_in        = S_READ;
                  end
               end
               default: begin
                  if (stat.out_free) begin
                     ctrl.emit        = 1'b1;
                     ctrl.emit_status = STATUS_OK;
                     state_in         = S_IDLE;
                  end
               end
            endcase
         end
         S_READ: begin
            // One entry a cycle while the pending word can move on.
            if (!stat.pend || stat.out_free) begin
               if (stat.remain_zero) begin
                  state_in = S_IDLE;
               end else begin
                  ctrl.read_issue = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (!stat.remain_zero) begin
               ctrl.scan_issue = 1'b1;
            end else if (!stat.scan_pend) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               ctrl.emit        = 1'b1;
               ctrl.emit_status = STATUS_OK;
               ctrl.scan_commit = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A captured word is always decoded in the next cycle.
   `BDQ_ASSERT_NEXT(a_capture_decode, ctrl.capture, state_ff == S_DECODE, "capture not decoded")
   // A direct result is only loaded when the output register can take it.
   `BDQ_ASSERT_IMPL(a_emit_free, ctrl.emit, stat.out_free, "emit into busy output")
   // The scan never ends while a word is still in flight.
   `BDQ_ASSERT_IMPL(a_scan_drain, state_ff == S_FINISH, !stat.scan_pend, "scan left a word")

endmodule

@@ sv/bdq_datapath.sv @@
// Datapath of the bounded deque: entry ring memory, pointers, walk counters and output register.
`include "assert_macros.svh"

module bdq_datapath import bdq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  req_word_type  req_data,
   input  logic          rsp_stall,
   input  ctrl_cmd_type  ctrl,
   output dp_stat_type   stat,
   output logic          rsp_valid,
   output rsp_word_type  rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = (CW > 5) ? CW : 5;
   localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // Ring position a + b, with both below DEPTH.
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   logic [31:0]   mem [DEPTH];
   logic [31:0]   mem_q_ff;

   logic [3:0]    cmd_ff;
   logic [31:0]   value_ff;
   logic [4:0]    k_ff;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [CW-1:0] kept_ff, kept_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;
   logic          scan_pend_ff;

   logic          out_valid_ff;
   rsp_word_type  out_data_ff;
   logic          out_free;

   logic [KW-1:0] k_ext, c_ext, n_k;
   logic [CW-1:0] read_n, start_off;
   logic [AW-1:0] head_dec, push_addr, pop_addr, read_base;
   logic [AW-1:0] raddr, waddr;
   logic          mem_re, mem_we, scan_keep;

   // Captured request word.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff   <= req_data.cmd;
         value_ff <= req_data.value;
         k_ff     <= req_data.count_k;
      end
   end

   // Read length and start offset for the read commands.
   always_comb begin
      k_ext     = KW'(k_ff);
      c_ext     = KW'(count_ff);
      n_k       = (k_ext < c_ext) ? k_ext : c_ext;
      read_n    = (cmd_ff == CMD_READ_ALL) ? count_ff : CW'(n_k);
      start_off = (cmd_ff == CMD_READ_TAIL) ? (count_ff - read_n) : '0;
   end

   // Ring addresses of the single-entry operations.
   always_comb begin
      head_dec  = (head_ff == '0) ? LAST_SLOT : (head_ff - AW'(1));
      push_addr = (cmd_ff == CMD_PUSH_FRONT) ? head_dec : wrap_add(head_ff, AW'(count_ff));
      pop_addr  = (cmd_ff == CMD_POP_FRONT) ? head_ff
                                            : wrap_add(head_ff, AW'(count_ff - CW'(1)));
      read_base = wrap_add(head_ff, AW'(start_off));
   end

   // Memory port selection; a kept word is written back during the scan.
   always_comb begin
      scan_keep = scan_pend_ff && (mem_q_ff != value_ff);
      mem_re    = ctrl.pop_issue || ctrl.read_issue || ctrl.scan_issue;
      raddr     = ctrl.pop_issue ? pop_addr : rd_addr_ff;
      mem_we    = ctrl.push_write || scan_keep;
      waddr     = scan_keep ? wr_addr_ff : push_addr;
   end

   // Entry ring memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= scan_keep ? mem_q_ff : value_ff;
      end
      if (mem_re) begin
         mem_q_ff <= mem[raddr];
      end
   end

   assign out_free = !out_valid_ff || !rsp_stall;

   // Next values of pointers and walk counters.
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      rd_addr_in   = rd_addr_ff;
      wr_addr_in   = wr_addr_ff;
      remain_in    = remain_ff;
      kept_in      = kept_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;

      // The pending word leaves once the output register takes it.
      if (pend_ff && out_free) begin
         pend_in = 1'b0;
      end

      if (ctrl.push_write) begin
         if (cmd_ff == CMD_PUSH_FRONT) begin
            head_in = head_dec;
         end
         count_in = count_ff + CW'(1);
      end
      if (ctrl.pop_issue) begin
         if (cmd_ff == CMD_POP_FRONT) begin
            head_in = wrap_add(head_ff, AW'(1));
         end
         count_in     = count_ff - CW'(1);
         remain_in    = '0;
         pend_in      = 1'b1;
         pend_last_in = 1'b1;
      end
      if (ctrl.clear_list) begin
         head_in  = '0;
         count_in = '0;
      end
      if (ctrl.read_start) begin
         rd_addr_in = read_base;
         remain_in  = read_n;
      end
      if (ctrl.read_issue) begin
         rd_addr_in   = wrap_add(rd_addr_ff, AW'(1));
         remain_in    = remain_ff - CW'(1);
         pend_in      = 1'b1;
         pend_last_in = (remain_ff == CW'(1));
      end
      if (ctrl.scan_start) begin
         rd_addr_in = head_ff;
         wr_addr_in = head_ff;
         remain_in  = count_ff;
         kept_in    = '0;
      end
      if (ctrl.scan_issue) begin
         rd_addr_in = wrap_add(rd_addr_ff, AW'(1));
         remain_in  = remain_ff - CW'(1);
      end
      if (scan_keep) begin
         wr_addr_in = wrap_add(wr_addr_ff, AW'(1));
         kept_in    = kept_ff + CW'(1);
      end
      if (ctrl.scan_commit) begin
         count_in = kept_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         kept_ff      <= '0;
         pend_ff      <= 1'b0;
         scan_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         kept_ff      <= kept_in;
         pend_ff      <= pend_in;
         scan_pend_ff <= ctrl.scan_issue;
         if (out_free) begin
            out_valid_ff <= ctrl.emit || pend_ff;
         end
      end
   end

   // Walk addresses and pending flag.
   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      wr_addr_ff   <= wr_addr_in;
      pend_last_ff <= pend_last_in;
   end

   // Output word: a direct status result or the pending entry.
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (ctrl.emit) begin
            out_data_ff.item        <= '0;
            out_data_ff.has_item    <= 1'b0;
            out_data_ff.item_last   <= 1'b1;
            out_data_ff.status      <= ctrl.emit_status;
            out_data_ff.entries_now <= ENW'(count_in);
         end else if (pend_ff) begin
            out_data_ff.item        <= $signed(mem_q_ff);
            out_data_ff.has_item    <= 1'b1;
            out_data_ff.item_last   <= pend_last_ff;
            out_data_ff.status      <= STATUS_OK;
            out_data_ff.entries_now <= ENW'(count_ff);
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Status to the controller.
   always_comb begin
      stat             = '0;
      stat.cmd         = cmd_ff;
      stat.list_empty  = (count_ff == '0);
      stat.list_full   = (count_ff == DEPTH_C);
      stat.read_none   = (read_n == '0);
      stat.remain_zero = (remain_ff == '0);
      stat.pend        = pend_ff;
      stat.scan_pend   = scan_pend_ff;
      stat.out_free    = out_free;
   end

   // The list never holds more than the ring.
   `BDQ_ASSERT(a_count_bound, count_ff <= DEPTH_C, "entry count above depth")
   // A new read never overwrites a word that the output has not taken.
   `BDQ_ASSERT_IMPL(a_pend_safe, ctrl.read_issue, !pend_ff || out_free, "pending word lost")
   // Survivors always trail the words read during a scan.
   `BDQ_ASSERT_IMPL(a_kept_bound, scan_pend_ff, kept_ff < count_ff, "scan kept too many")

endmodule

@@ sv/bounded_deque_with_value_removal.sv @@
// Top level of the bounded deque of signed 32-bit words with value removal.
//
// Request channel (req_valid, req_stall, req_data) takes one command word:
// push front or back, pop front or back, remove every match of a value,
// clear, or read all entries, the first k or the last k.
// Response channel (rsp_valid, rsp_stall, rsp_data) returns one word per
// entry read, or a single status word for every other command; item_last
// marks the final word of each command.
// Commands are handled one at a time. A push, clear, unknown command or a
// read that returns no entry is answered from the decode state, a pop from
// one memory read. A read of n entries streams one word a cycle while the
// receiver does not stall; a removal walks every entry through the single
// memory read port before its status word.
// The ring memory has one read and one write port.
// An output register parts the two channels: a finished word waits there
// while the next command is taken. When the receiver stalls, the read walk pauses
// and the held word does not change.
// Reset is synchronous and empties the list; entries hold no reset value and
// need no clearing pass.
module bounded_deque_with_value_removal import bdq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_word_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_word_type  rsp_data
);

   ctrl_cmd_type ctrl;
   dp_stat_type  stat;

   // Command sequencing.
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // Storage, pointers and output register.
   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the bounded deque: a directed table, then random commands.
module testbench import bdq_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH   = 16;
   localparam int RANDOM_ITEMS = 80;
   localparam int QUIET_LIMIT  = 3000;
   localparam int SETTLE_TAIL  = 40;

   // Codes that the block does not decode.
   localparam logic [3:0] CMD_UNUSED_LOW = 4'd9;
   localparam logic [3:0] CMD_UNUSED_TOP = 4'd15;

   typedef enum int {STALL_NEVER, STALL_SCATTER, STALL_RUNS} stall_mode_type;

   // One row of the directed table, with an optional typed-in reply.
   typedef struct {
      req_word_type req;
      int           times;
      bit           typed;
      rsp_word_type reply;
   } plan_row_type;

   typedef struct {
      bit           typed;
      rsp_word_type reply;
   } reply_override_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   // Shadow copy of the ring.
   logic [31:0] ring [RING_DEPTH];
   logic [3:0]  ring_head = '0;
   logic [4:0]  ring_count = '0;

   rsp_word_type       replies_due[$];
   reply_override_type reply_overrides[$];
   plan_row_type       plan[$];
   logic [31:0]        recent_words[$];

   int             faults = 0;
   int             quiet_cycles = 0;
   int             burst_left = 0;
   int             stall_age = 0;
   int             stall_run = 0;
   stall_mode_type stall_mode = STALL_NEVER;
   logic           stall_next;

   bounded_deque_with_value_removal #(.DEPTH(RING_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A reply word; entries_now reflects the list after the command.
   function automatic rsp_word_type reply_word(logic [31:0] item, logic has, logic last_flag,
                                               logic [1:0] st);
      rsp_word_type w;
      w.item        = item;
      w.has_item    = has;
      w.item_last   = last_flag;
      w.status      = st;
      w.entries_now = ring_count;
      return w;
   endfunction

   // Words read out from list position start onward, front to back.
   function automatic void read_span(input logic [4:0] start, input logic [4:0] n,
                                     output rsp_word_type outs[$]);
      logic [3:0] idx;
      outs = {};
      if (ring_count == 0) begin
         outs.push_back(reply_word('0, 1'b0, 1'b1, STATUS_EMPTY));
      end else if (n == 0) begin
         outs.push_back(reply_word('0, 1'b0, 1'b1, STATUS_OK));
      end else begin
         for (int i = 0; i < n; i++) begin
            idx = ring_head + start[3:0] + 4'(i);
            outs.push_back(reply_word(ring[idx], 1'b1, (i + 1 == n), STATUS_OK));
         end
      end
   endfunction

   // Applies one command to the shadow ring and works out its reply words.
   function automatic void predict_deque(input req_word_type r, output rsp_word_type outs[$]);
      logic [4:0]  k;
      logic [4:0]  kept;
      logic [3:0]  idx;
      logic [31:0] v;
      outs = {};
      k = r.count_k;
      if (k > RING_DEPTH) k = 5'(RING_DEPTH);
      if (k > ring_count) k = ring_count;
      case (r.cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (ring_count >= RING_DEPTH) begin
               outs.push_back(reply_word('0, 1'b0, 1'b1, STATUS_FULL));
            end else begin
               if (r.cmd == CMD_PUSH_FRONT) begin
                  ring_head = ring_head - 4'd1;
                  ring[ring_head] = r.value;
               end else begin
                  idx = ring_head + ring_count[3:0];
                  ring[idx] = r.value;
               end
               ring_count++;
               outs.push_back(reply_word('0, 1'b0, 1'b1, STATUS_OK));
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (ring_count == 0) begin
               outs.push_back(reply_word('0, 1'b0, 1'b1, STATUS_EMPTY));
            end else begin
               if (r.cmd == CMD_POP_FRONT) begin
                  v = ring[ring_head];
                  ring_head = ring_head + 4'd1;
               end else begin
                  idx = ring_head + 4'(ring_count - 5'd1);
                  v = ring[idx];
               end
               ring_count--;
               outs.push_back(reply_word(v, 1'b1, 1'b1, STATUS_OK));
            end
         end
         CMD_REMOVE: begin
            // Survivors are packed towards the head in their old order.
            kept = '0;
            for (int i = 0; i < ring_count; i++) begin
               idx = ring_head + 4'(i);
               v = ring[idx];
               if (v != r.value) begin
                  idx = ring_head + kept[3:0];
                  ring[idx] = v;
                  kept++;
               end
            end
            ring_count = kept;
            outs.push_back(reply_word('0, 1'b0, 1'b1, STATUS_OK));
         end
         CMD_CLEAR: begin
            ring_count = '0;
            ring_head  = '0;
            outs.push_back(reply_word('0, 1'b0, 1'b1, STATUS_OK));
         end
         CMD_READ_ALL:   read_span('0, ring_count, outs);
         CMD_READ_FIRST: read_span('0, k, outs);
         CMD_READ_TAIL:  read_span(ring_count - k, k, outs);
         default:        outs.push_back(reply_word('0, 1'b0, 1'b1, STATUS_OK));
      endcase
   endfunction

   // On acceptance the reply is predicted, or taken from the table where typed in.
   function automatic void take_command(req_word_type r);
      reply_override_type ov;
      rsp_word_type       words[$];
      ov.typed = 1'b0;
      ov.reply = '0;
      if (reply_overrides.size() != 0) ov = reply_overrides.pop_front();
      predict_deque(r, words);
      if (ov.typed) replies_due.push_back(ov.reply);
      else foreach (words[i]) replies_due.push_back(words[i]);
   endfunction

   // Compares one reply word with the oldest expectation.
   function automatic void check_reply(rsp_word_type got);
      rsp_word_type want;
      if (replies_due.size() == 0) begin
         if (faults < 10)
            $display("unexpected reply: item %h has %b last %b status %0d entries %0d",
                     got.item, got.has_item, got.item_last, got.status, got.entries_now);
         faults++;
      end else begin
         want = replies_due.pop_front();
         if (got.item !== want.item || got.has_item !== want.has_item ||
             got.item_last !== want.item_last || got.status !== want.status ||
             got.entries_now !== want.entries_now) begin
            if (faults < 10)
               $display("mismatch: expected item %h has %b last %b status %0d entries %0d, %s",
                        want.item, want.has_item, want.item_last, want.status,
                        want.entries_now, "see actual below");
            if (faults < 10)
               $display("          actual   item %h has %b last %b status %0d entries %0d",
                        got.item, got.has_item, got.item_last, got.status, got.entries_now);
            faults++;
         end
      end
   endfunction

   // Monitor and watchdog: both channels are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) take_command(req_data);
         if (rsp_valid && !rsp_stall) check_reply(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Receiver stall pattern: never, scattered, or in runs, with the mode redrawn at random periodically.
   always @(posedge clock) begin
      stall_age++;
      if (stall_age % 48 == 0) stall_mode = stall_mode_type'($urandom_range(0, 2));
      case (stall_mode)
         STALL_NEVER:   stall_next = 1'b0;
         STALL_SCATTER: stall_next = ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run > 0) begin
               stall_next = 1'b1;
               stall_run--;
            end else begin
               stall_next = 1'b0;
               if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(2, 20);
            end
         end
      endcase
      rsp_stall <= stall_next;
   end

   function automatic void add_row(logic [3:0] c, logic [31:0] v, logic [4:0] k, int times,
                                   bit typed, logic [31:0] item, logic has, logic [1:0] st,
                                   logic [4:0] n);
      plan_row_type row;
      row.req.cmd           = c;
      row.req.value         = v;
      row.req.count_k       = k;
      row.times             = times;
      row.typed             = typed;
      row.reply.item        = item;
      row.reply.has_item    = has;
      row.reply.item_last   = 1'b1;
      row.reply.status      = st;
      row.reply.entries_now = n;
      plan.push_back(row);
   endfunction

   // Many small values so that removal finds matches, with extremes, full-range noise and recent words.
   function automatic logic [31:0] random_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return 32'($urandom_range(0, 8)) - 32'd4;
      else if (sel < 7) return $urandom;
      else if (sel < 9) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      else return recent_words.size() != 0 ?
                  recent_words[$urandom_range(0, recent_words.size() - 1)] : 32'd0;
   endfunction

   // A random command; filling phases favour pushes, draining phases favour pops.
   function automatic req_word_type random_command(bit filling);
      req_word_type w;
      int pick;
      int rest;
      int push_share;
      int pop_share;
      push_share = filling ? 50 : 15;
      pop_share  = filling ? 10 : 35;
      pick = $urandom_range(0, 99);
      w.value   = random_value();
      w.count_k = 5'($urandom_range(0, 31));
      if (pick < push_share) begin
         w.cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
         recent_words.push_back(w.value);
         if (recent_words.size() > RING_DEPTH) void'(recent_words.pop_front());
      end else if (pick < push_share + pop_share) begin
         w.cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end else begin
         rest = $urandom_range(0, 39);
         if (rest < 12) begin
            w.cmd = CMD_REMOVE;
            if (recent_words.size() != 0 && $urandom_range(0, 9) < 7)
               w.value = recent_words[$urandom_range(0, recent_words.size() - 1)];
         end else if (rest < 20) w.cmd = CMD_READ_ALL;
         else if (rest < 27) w.cmd = CMD_READ_FIRST;
         else if (rest < 34) w.cmd = CMD_READ_TAIL;
         else if (rest < 37) w.cmd = CMD_CLEAR;
         else w.cmd = 4'($urandom_range(CMD_UNUSED_TOP, CMD_UNUSED_LOW));
      end
      return w;
   endfunction

   // Sends one word in bursts with random gaps, and returns once it is accepted.
   task automatic send_word(req_word_type w, bit typed, rsp_word_type reply);
      reply_override_type ov;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      ov.typed = typed;
      ov.reply = reply;
      reply_overrides.push_back(ov);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Holds the sender off until every expected reply has come back.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   initial begin
      rsp_word_type blank;
      blank = '0;

      // Empty list, unknown code, extremes, saturated counts, full list, compaction.
      add_row(CMD_POP_FRONT,  32'd0,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_EMPTY, 5'd0);
      add_row(CMD_POP_BACK,   32'd0,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_EMPTY, 5'd0);
      add_row(CMD_READ_ALL,   32'd0,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_EMPTY, 5'd0);
      add_row(CMD_READ_TAIL,  32'd0,         5'd16, 1, 1, 32'd0, 1'b0, STATUS_EMPTY, 5'd0);
      add_row(CMD_REMOVE,     32'd0,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd0);
      add_row(CMD_CLEAR,      32'd0,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd0);
      add_row(CMD_UNUSED_TOP, 32'hFFFF_FFFF, 5'd31, 1, 1, 32'd0, 1'b0, STATUS_OK,    5'd0);
      add_row(CMD_PUSH_BACK,  32'h7FFF_FFFF, 5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd1);
      add_row(CMD_PUSH_FRONT, 32'h8000_0000, 5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd2);
      add_row(CMD_PUSH_BACK,  32'hFFFF_FFFF, 5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd3);
      add_row(CMD_PUSH_BACK,  32'd0,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd4);
      add_row(CMD_READ_ALL,   32'd0,         5'd0,  1, 0, 32'd0, 1'b0, STATUS_OK,    5'd0);
      add_row(CMD_READ_FIRST, 32'd0,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd4);
      add_row(CMD_READ_FIRST, 32'd0,         5'd31, 1, 0, 32'd0, 1'b0, STATUS_OK,    5'd0);
      add_row(CMD_READ_TAIL,  32'd0,         5'd2,  1, 0, 32'd0, 1'b0, STATUS_OK,    5'd0);
      add_row(CMD_REMOVE,     32'hFFFF_FFFF, 5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd3);
      add_row(CMD_POP_BACK,   32'd0,         5'd0,  1, 1, 32'd0, 1'b1, STATUS_OK,    5'd2);
      add_row(CMD_POP_FRONT,  32'd0,         5'd0,  1, 1, 32'h8000_0000, 1'b1, STATUS_OK, 5'd1);
      // Fifteen pushes fill the list around the ring; the sixteenth is dropped.
      add_row(CMD_PUSH_FRONT, 32'd5,         5'd0, 16, 0, 32'd0, 1'b0, STATUS_OK,    5'd0);
      add_row(CMD_READ_TAIL,  32'd0,         5'd16, 1, 0, 32'd0, 1'b0, STATUS_OK,    5'd0);
      add_row(CMD_PUSH_BACK,  32'd3,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_FULL,  5'd16);
      add_row(CMD_REMOVE,     32'd5,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd1);
      add_row(CMD_CLEAR,      32'd0,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd0);
      add_row(CMD_UNUSED_LOW, 32'd0,         5'd0,  1, 1, 32'd0, 1'b0, STATUS_OK,    5'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i])
         for (int t = 0; t < plan[i].times; t++)
            send_word(plan[i].req, plan[i].typed, plan[i].reply);
      hold_until_drained();

      // Random part, alternating filling and draining phases of 25 words.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) hold_until_drained();
         send_word(random_command((n / 25) % 2 == 0), 1'b0, blank);
      end
      hold_until_drained();
      repeat (SETTLE_TAIL) @(posedge clock);

      if (faults == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
